// File: design/radix2_fft_real_input_assert.svh
// Assertion macros shared by the FFT checker.
// Depends on nothing; included by the checker file.
`ifndef RADIX2_FFT_REAL_INPUT_ASSERT_SVH
`define RADIX2_FFT_REAL_INPUT_ASSERT_SVH
// Implication checked on every clock, skipped during reset.
`define R2F_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, skipped during reset.
`define R2F_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/r2f_pkg.sv
// Package for the radix-2 FFT: constants, types, twiddle and saturation functions.
// Depends on nothing.
`default_nettype none
package r2f_pkg;
  localparam int MaxPoints  = 1024;
  localparam int SampleBits = 16;
  localparam int DataBits   = 27;
  localparam int TwBits     = 16;
  localparam int CfgBits    = 4;
  localparam int IdxBits    = 10;
  localparam logic [0:0] KIND_LOAD = 1'b0;
  localparam logic [0:0] KIND_READ = 1'b1;
  localparam longint unsigned PiQ60 = 64'h3243F6A8885A308D;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD_A, ST_RD_B, ST_CALC, ST_WR_A, ST_WR_B, ST_OUT
  } fsm_t;

  // Long division of non-negative values, for table building at elaboration.
  function automatic longint udiv(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int i = 62; i >= 0; i--) begin
      rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'sd1 <<< i);
      end
    end
    return quo;
  endfunction

  // Quarter-wave twiddle entry q of a 2**lg_n point table: Taylor series of
  // the Q30 angle, rounded to Q1.15 and held to 0..32767.
  function automatic logic signed [TwBits-1:0] tw_entry(input int q, input int lg_n,
                                                      input bit want_sin);
    longint unsigned qu;
    longint unsigned th_u;
    longint th, x2, ts, tc, s, c, v, r;
    qu = q;
    th_u = (((qu * (PiQ60 >> 15)) >> lg_n) + 64'd8192) >> 14;
    th = th_u;
    x2 = (th * th) >>> 30;
    ts = th;
    tc = 64'sd1 <<< 30;
    s = th;
    c = 64'sd1 <<< 30;
    for (int n = 1; n <= 12; n++) begin
      ts = udiv((ts * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
      tc = udiv((tc * x2) >>> 30, longint'((2 * n - 1) * (2 * n)));
      if ((n & 1) == 1) begin
        s = s - ts;
        c = c - tc;
      end else begin
        s = s + ts;
        c = c + tc;
      end
    end
    v = want_sin ? s : c;
    if (v < 0) v = 0;
    r = (v + (64'sd1 <<< 14)) >>> 15;
    if (r > 32767) r = 32767;
    return TwBits'(r);
  endfunction

  // Saturate a sum to the data width.
  function automatic logic signed [DataBits-1:0] sat(input logic signed [DataBits+1:0] v);
    logic signed [DataBits+1:0] hi;
    logic signed [DataBits+1:0] lo;
    hi = (DataBits+2)'(67108863);
    lo = -(DataBits+2)'(67108864);
    if (v > hi) return hi[DataBits-1:0];
    if (v < lo) return lo[DataBits-1:0];
    return v[DataBits-1:0];
  endfunction
endpackage
`default_nettype wire

// File: design/r2f_if.sv
// Valid/ready channel interfaces for the FFT input and result streams.
// Depends on r2f_pkg for the field widths.
`default_nettype none
interface r2f_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic signed [r2f_pkg::SampleBits-1:0] sample;
  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface

interface r2f_out_if;
  logic               valid;
  logic               ready;
  logic        [r2f_pkg::IdxBits-1:0]  bin_index;
  logic signed [r2f_pkg::DataBits-1:0] real_part;
  logic signed [r2f_pkg::DataBits-1:0] imag_part;
  logic               last_bin;
  modport source (output valid, bin_index, real_part, imag_part, last_bin, input ready);
  modport sink   (input valid, bin_index, real_part, imag_part, last_bin, output ready);
endinterface
`default_nettype wire

// File: design/r2f_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module r2f_ram #(
  parameter int Width = 54,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/radix2_fft_real_input.sv
// In-place radix-2 DIT FFT of a real frame of 2**log2_size points held in one
// RAM. Loads are accepted back to back while no result waits and are stored at
// bit-reversed addresses. After the last load the block runs (size/2)*log2(size)
// butterflies, each as read A, read B, multiply, write A, write B on the RAM's
// read and write ports; no transaction is accepted meanwhile. Reads return bins
// in natural order: an accepted read moves the block to its output state, which
// registers the result and raises valid. The next transaction is accepted in the
// cycle after the result is taken. Writing log2_size abandons the current frame.
// Depends on r2f_pkg, r2f_if, r2f_ram.
`default_nettype none
module radix2_fft_real_input #(
  parameter int MaxPoints = r2f_pkg::MaxPoints
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic                          cfg_we,
  input  wire logic [r2f_pkg::CfgBits-1:0]   cfg_data,
  r2f_in_if.sink    in_ch,
  r2f_out_if.source out_ch
);
  localparam int AW = $clog2(MaxPoints);
  localparam int Quarter = MaxPoints / 4;
  localparam int HalfPoints = MaxPoints / 2;
  localparam int DW = r2f_pkg::DataBits;

  logic [r2f_pkg::CfgBits-1:0] log2_size;
  logic [AW:0]   load_count;
  logic [AW-1:0] read_count;
  logic          frame_ready;
  r2f_pkg::fsm_t state, state_next;

  // Butterfly counters.
  logic [4:0]    stage;     // log2 of half
  logic [AW-1:0] bfly;      // butterfly number within stage
  logic [AW-1:0] addr_a, addr_b;
  logic signed [DW-1:0] ar, ai, br, bi;
  logic signed [DW+1:0] vr, vi;
  logic signed [r2f_pkg::TwBits-1:0] tc, ts;

  // Effective log2 and size.
  logic [4:0] lg;
  always_comb begin
    lg = (32'(log2_size) > AW) ? 5'(AW) : 5'(log2_size);
  end
  logic [AW:0] size;
  assign size = (AW+1)'(1) << lg;

  // Bit-reverse the load address within lg bits.
  logic [AW-1:0] rev_addr;
  always_comb begin
    rev_addr = '0;
    for (int i = 0; i < AW; i++) begin
      if (i < 32'(lg)) rev_addr[32'(lg) - 1 - i] = load_count[i];
    end
  end

  // Butterfly addresses and twiddle index.
  logic [AW-1:0] half, k_idx, grp, m_idx;
  always_comb begin
    half   = AW'(1) << stage;
    k_idx  = bfly & (half - AW'(1));
    grp    = (bfly >> stage) << (stage + 5'd1);
    addr_a = grp | k_idx;
    addr_b = addr_a | half;
    m_idx  = AW'(32'(k_idx) << (AW - 1 - 32'(stage)));
  end

  // Twiddle tables, fixed at elaboration.
  wire logic signed [r2f_pkg::TwBits-1:0] cos_rom [Quarter+1];
  wire logic signed [r2f_pkg::TwBits-1:0] sin_rom [Quarter+1];
  for (genvar q = 0; q <= Quarter; q++) begin : g_rom
    localparam logic signed [r2f_pkg::TwBits-1:0] CosQ = r2f_pkg::tw_entry(q, AW, 1'b0);
    localparam logic signed [r2f_pkg::TwBits-1:0] SinQ = r2f_pkg::tw_entry(q, AW, 1'b1);
    assign cos_rom[q] = CosQ;
    assign sin_rom[q] = SinQ;
  end
  localparam int QW = $clog2(Quarter + 1);
  logic [AW-1:0] t_idx;
  always_comb begin
    t_idx = AW'(HalfPoints) - m_idx;
  end

  // RAM.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [2*DW-1:0]     ram_wdata, ram_rdata;
  r2f_ram #(.Width(2*DW), .Depth(MaxPoints)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // B operand straight from the RAM read in the multiply step.
  assign br = ram_rdata[2*DW-1:DW];
  assign bi = ram_rdata[DW-1:0];

  // Products, registered in the multiply step.
  logic signed [DW+16:0] p_rr, p_is, p_ic, p_rs;
  logic signed [DW+17:0] sr, si;
  always_comb begin
    sr = (DW+18)'(p_rr) + (DW+18)'(p_is) + (DW+18)'(16384);
    si = (DW+18)'(p_ic) - (DW+18)'(p_rs) + (DW+18)'(16384);
    vr = (DW+2)'(sr >>> 15);
    vi = (DW+2)'(si >>> 15);
  end

  logic last_bfly;
  assign last_bfly = (32'(bfly) == 32'(size >> 1) - 1) && (32'(stage) == 32'(lg) - 1);

  logic in_fire, load_fire, read_fire;
  assign in_ch.ready = (state == r2f_pkg::ST_LOAD) && !out_ch.valid;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign load_fire = in_fire && (in_ch.kind == r2f_pkg::KIND_LOAD);
  assign read_fire = in_fire && (in_ch.kind == r2f_pkg::KIND_READ) && frame_ready;

  // Next state and RAM port control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = addr_a;
    ram_raddr  = addr_a;
    ram_wdata  = '0;
    unique case (state)
      r2f_pkg::ST_LOAD: begin
        ram_raddr = read_count;
        ram_waddr = rev_addr;
        ram_wdata = {DW'(in_ch.sample), DW'(0)};
        if (load_fire) begin
          ram_we = 1'b1;
          if (load_count + 1'b1 >= size && lg != 5'd0) state_next = r2f_pkg::ST_RD_A;
        end else if (read_fire) begin
          state_next = r2f_pkg::ST_OUT;
        end
      end
      r2f_pkg::ST_RD_A: begin
        ram_raddr = addr_a;
        state_next = r2f_pkg::ST_RD_B;
      end
      r2f_pkg::ST_RD_B: begin
        ram_raddr = addr_b;
        state_next = r2f_pkg::ST_CALC;
      end
      r2f_pkg::ST_CALC: state_next = r2f_pkg::ST_WR_A;
      r2f_pkg::ST_WR_A: begin
        ram_we = 1'b1;
        ram_waddr = addr_a;
        ram_wdata = {r2f_pkg::sat((DW+2)'(ar) + vr), r2f_pkg::sat((DW+2)'(ai) + vi)};
        state_next = r2f_pkg::ST_WR_B;
      end
      r2f_pkg::ST_WR_B: begin
        ram_we = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = {r2f_pkg::sat((DW+2)'(ar) - vr), r2f_pkg::sat((DW+2)'(ai) - vi)};
        state_next = last_bfly ? r2f_pkg::ST_LOAD : r2f_pkg::ST_RD_A;
      end
      r2f_pkg::ST_OUT: state_next = r2f_pkg::ST_LOAD;
      default: state_next = r2f_pkg::ST_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= r2f_pkg::ST_LOAD;
      log2_size <= r2f_pkg::CfgBits'(10);
      load_count <= '0;
      read_count <= '0;
      frame_ready <= 1'b0;
      stage <= '0;
      bfly <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (state == r2f_pkg::ST_OUT) out_ch.valid <= 1'b1;
      if (cfg_we) begin
        log2_size <= cfg_data;
        load_count <= '0;
        read_count <= '0;
        frame_ready <= 1'b0;
      end else if (load_fire) begin
        stage <= '0;
        bfly <= '0;
        if (load_count + 1'b1 >= size) begin
          load_count <= '0;
          read_count <= '0;
          frame_ready <= 1'b1;
        end else begin
          load_count <= load_count + 1'b1;
          frame_ready <= 1'b0;
          read_count <= '0;
        end
      end else if (read_fire) begin
        if (32'(read_count) + 1 >= 32'(size)) begin
          frame_ready <= 1'b0;
          read_count <= '0;
        end else begin
          read_count <= read_count + 1'b1;
        end
      end
      // Advance butterfly counters.
      if (state == r2f_pkg::ST_WR_B && !last_bfly) begin
        if (32'(bfly) == 32'(size >> 1) - 1) begin
          bfly <= '0;
          stage <= stage + 5'd1;
        end else begin
          bfly <= bfly + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == r2f_pkg::ST_RD_B) begin
      ar <= ram_rdata[2*DW-1:DW];
      ai <= ram_rdata[DW-1:0];
      if (32'(m_idx) <= Quarter) begin
        tc <= cos_rom[QW'(m_idx)];
        ts <= sin_rom[QW'(m_idx)];
      end else begin
        tc <= -cos_rom[QW'(t_idx)];
        ts <= sin_rom[QW'(t_idx)];
      end
    end
    // Multiply the B operand as it leaves the RAM.
    if (state == r2f_pkg::ST_CALC) begin
      p_rr <= (DW+17)'(br) * (DW+17)'(tc);
      p_is <= (DW+17)'(bi) * (DW+17)'(ts);
      p_ic <= (DW+17)'(bi) * (DW+17)'(tc);
      p_rs <= (DW+17)'(br) * (DW+17)'(ts);
    end
    if (state == r2f_pkg::ST_LOAD && read_fire) begin
      out_ch.bin_index <= r2f_pkg::IdxBits'(read_count);
      out_ch.last_bin  <= (32'(read_count) + 1 >= 32'(size));
    end
    if (state == r2f_pkg::ST_OUT) begin
      out_ch.real_part <= ram_rdata[2*DW-1:DW];
      out_ch.imag_part <= ram_rdata[DW-1:0];
    end
  end
endmodule
`default_nettype wire

// File: design/r2f_checker.sv
// Port-level checker for the FFT block, bound to the top level.
// Depends on radix2_fft_real_input_assert.svh.
`default_nettype none
`include "radix2_fft_real_input_assert.svh"
module r2f_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic last_bin
);
  // Input is held off while a result waits.
  `R2F_ASSERT_IMPL(a_no_in_while_out, clk, rst, out_valid, !in_ready, "input accepted with result pending")
  // A result leaves valid once taken.
  `R2F_ASSERT_NEXT(a_out_drop, clk, rst, out_valid && out_ready, !out_valid, "result repeated")
  // A stalled result holds.
  `R2F_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(last_bin), "stalled result changed")
endmodule
bind radix2_fft_real_input r2f_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .last_bin(out_ch.last_bin)
);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the radix-2 real-input FFT: directed cases and
// random frames of loads and reads, with a transaction-level frame model as the predictor.
// Depends on r2f_pkg, r2f_if and the radix2_fft_real_input design.
`default_nettype none
module tb;
  typedef struct {
    logic              kind;
    logic signed [15:0] sample;
  } fft_op_t;

  typedef struct {
    logic        [9:0]  bin_index;
    logic signed [26:0] real_part;
    logic signed [26:0] imag_part;
    logic               last_bin;
  } fft_bin_t;

  localparam int         WatchLimit = 100000;
  localparam longint     PiQ60      = 64'h3243F6A8885A308D;
  localparam longint     BinMax     = 67108863;
  localparam longint     BinMin     = -67108864;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [r2f_pkg::CfgBits-1:0] cfg_data;

  r2f_in_if  in_ch ();
  r2f_out_if out_ch ();

  radix2_fft_real_input dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Frame model state
  longint tw_cos_q[0:256];
  longint tw_sin_q[0:256];
  longint frame_re[0:1023];
  longint frame_im[0:1023];
  int     fill_count;
  int     bin_count;
  bit     bins_ready;
  int     size_log2;

  fft_op_t  op_queue[$];
  fft_bin_t bin_queue[$];
  int       fail_count;
  int       ops_sent;
  int       idle_cycles;
  bit       burst_mode;
  bit       hold_request;

  // Clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_q15(longint v);
    longint r;
    if (v < 0) v = 0;
    r = (v + (64'sd1 << 14)) >>> 15;
    if (r > 32767) r = 32767;
    return r;
  endfunction

  function automatic longint sat_bin(longint v);
    if (v > BinMax) return BinMax;
    if (v < BinMin) return BinMin;
    return v;
  endfunction

  function automatic longint round_tw(longint v);
    return (v + (64'sd1 << 14)) >>> 15;
  endfunction

  // Build the quarter-wave twiddle table with the integer Taylor series
  function automatic void build_twiddles();
    longint unsigned th_u;
    longint th, x2, ts, tc, s, c;
    for (int q = 0; q <= 256; q++) begin
      th_u = ((longint'(q) * (PiQ60 >> 15)) / 1024 + 8192) >> 14;
      th = longint'(th_u);
      x2 = (th * th) >>> 30;
      ts = th;
      tc = 64'sd1 << 30;
      s = th;
      c = 64'sd1 << 30;
      for (int n = 1; n <= 12; n++) begin
        ts = ((ts * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >>> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          s -= ts;
          c -= tc;
        end else begin
          s += ts;
          c += tc;
        end
      end
      tw_cos_q[q] = clamp_q15(c);
      tw_sin_q[q] = clamp_q15(s);
    end
  endfunction

  function automatic void run_butterflies(int size);
    int stride, m, a, b, t;
    longint c, s, vr, vi, ar, ai, br, bi;
    for (int half = 1; half < size; half *= 2) begin
      stride = 1024 / (2 * half);
      for (int base = 0; base < size; base += 2 * half) begin
        for (int k = 0; k < half; k++) begin
          m = k * stride;
          a = base + k;
          b = a + half;
          if (m <= 256) begin
            c = tw_cos_q[m];
            s = tw_sin_q[m];
          end else begin
            t = 512 - m;
            if (t > 256) t = 256;
            c = -tw_cos_q[t];
            s = tw_sin_q[t];
          end
          ar = frame_re[a];
          ai = frame_im[a];
          br = frame_re[b];
          bi = frame_im[b];
          vr = round_tw(br * c + bi * s);
          vi = round_tw(bi * c - br * s);
          frame_re[a] = sat_bin(ar + vr);
          frame_im[a] = sat_bin(ai + vi);
          frame_re[b] = sat_bin(ar - vr);
          frame_im[b] = sat_bin(ai - vi);
        end
      end
    end
  endfunction

  function automatic int bit_reverse(int v, int bits);
    int r;
    r = 0;
    for (int i = 0; i < bits; i++) r |= ((v >> i) & 1) << (bits - 1 - i);
    return r;
  endfunction

  function automatic void fft_set_size(int v);
    size_log2 = (v > 10) ? 10 : v;
    fill_count = 0;
    bin_count = 0;
    bins_ready = 1'b0;
  endfunction

  // Advance the frame model by one accepted transaction
  function automatic void fft_predict(fft_op_t op);
    int size, addr;
    fft_bin_t bin;
    size = 1 << size_log2;
    if (op.kind == r2f_pkg::KIND_LOAD) begin
      if (bins_ready) begin
        bins_ready = 1'b0;
        bin_count = 0;
      end
      if (fill_count >= size) fill_count = 0;
      addr = bit_reverse(fill_count, size_log2);
      frame_re[addr] = longint'(op.sample);
      frame_im[addr] = 0;
      fill_count++;
      if (fill_count >= size) begin
        run_butterflies(size);
        fill_count = 0;
        bin_count = 0;
        bins_ready = 1'b1;
      end
    end else if (bins_ready) begin
      bin.bin_index = bin_count[9:0];
      bin.real_part = frame_re[bin_count][26:0];
      bin.imag_part = frame_im[bin_count][26:0];
      bin.last_bin  = (bin_count + 1 >= size);
      bin_queue.push_back(bin);
      if (bin.last_bin) begin
        bins_ready = 1'b0;
        bin_count = 0;
      end else begin
        bin_count++;
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Drive input transactions from the pending queue
  int in_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fft_predict(op_queue.pop_front());
        in_gap = pick_gap();
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          in_ch.valid  <= 1'b1;
          in_ch.kind   <= op_queue[0].kind;
          in_ch.sample <= op_queue[0].sample;
          ops_sent++;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Check result transactions and pace the ready line
  int out_gap;
  int hold_left;
  always @(posedge clk) begin
    fft_bin_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (bin_queue.size() == 0) begin
          report_mismatch("unexpected bin", longint'(out_ch.bin_index), -1);
        end else begin
          want = bin_queue.pop_front();
          if (out_ch.bin_index !== want.bin_index)
            report_mismatch("bin_index", out_ch.bin_index, want.bin_index);
          if (out_ch.real_part !== want.real_part)
            report_mismatch("real_part", out_ch.real_part, want.real_part);
          if (out_ch.imag_part !== want.imag_part)
            report_mismatch("imag_part", out_ch.imag_part, want.imag_part);
          if (out_ch.last_bin !== want.last_bin)
            report_mismatch("last_bin", out_ch.last_bin, want.last_bin);
        end
      end
      // Start the long hold once a result is waiting
      if (hold_request && out_ch.valid) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Watchdog: count cycles with work pending and no transaction
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (op_queue.size() > 0 || bin_queue.size() > 0) begin
      idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_load(logic signed [15:0] v);
    fft_op_t op;
    op.kind = r2f_pkg::KIND_LOAD;
    op.sample = v;
    op_queue.push_back(op);
  endtask

  task automatic queue_read(int count);
    fft_op_t op;
    op.kind = r2f_pkg::KIND_READ;
    op.sample = 16'($urandom);
    repeat (count) op_queue.push_back(op);
  endtask

  // Wait until all traffic is done, then let a transform finish
  task automatic settle();
    int size;
    while (op_queue.size() > 0 || bin_queue.size() > 0 || in_ch.valid) @(posedge clk);
    size = 1 << size_log2;
    repeat ((size / 2) * size_log2 * 5 + 50) @(posedge clk);
  endtask

  task automatic write_size(int v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= r2f_pkg::CfgBits'(v);
    fft_set_size(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One frame of random samples, with occasional broken sequences
  task automatic queue_frame();
    int size, r;
    size = 1 << size_log2;
    for (int i = 0; i < size; i++) begin
      if ($urandom_range(0, 29) == 0) queue_read(1);
      queue_load(16'($urandom));
    end
    r = $urandom_range(0, 9);
    if (r == 0) queue_read($urandom_range(0, size - 1));
    else if (r == 1) queue_read(size + $urandom_range(1, 3));
    else queue_read(size);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = r2f_pkg::KIND_LOAD;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    ops_sent = 0;
    burst_mode = 1'b0;
    hold_request = 1'b0;
    build_twiddles();
    for (int i = 0; i < 1024; i++) begin
      frame_re[i] = 0;
      frame_im[i] = 0;
    end
    fft_set_size(10);
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reads with no frame, then a partial frame abandoned by a size write
    queue_read(2);
    queue_load(16'sh7fff);
    queue_load(-16'sh8000);
    settle();

    // Size one passes samples through
    write_size(0);
    queue_load(16'sh7fff);
    queue_read(1);
    queue_load(-16'sh8000);
    queue_read(2);
    settle();

    // Size two at the extremes, then a load during readout
    write_size(1);
    queue_load(16'sh7fff);
    queue_load(-16'sh8000);
    queue_read(1);
    queue_load(-16'sh8000);
    queue_load(-16'sh8000);
    queue_read(2);
    settle();

    write_size(2);
    queue_load(16'sh7fff);
    queue_load(16'sh7fff);
    queue_load(16'sh7fff);
    queue_load(16'sh7fff);
    queue_read(4);
    settle();

    // Long receiver hold on the first result while the sender keeps offering
    write_size(6);
    burst_mode = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 64; i++) queue_load(16'($urandom));
    queue_read(64);
    settle();
    burst_mode = 1'b0;

    // Random phases at small sizes
    while (ops_sent < 350) begin
      write_size($urandom_range(0, 7));
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) queue_frame();
      settle();
    end

    // One frame at 256 points
    burst_mode = 1'b0;
    write_size(8);
    queue_frame();
    settle();

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
